FILE: hdl/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  // Number of task descriptors the store can hold.
  localparam int unsigned TASK_MAX = 16;

  // Widths of the fixed input and result fields.
  localparam int unsigned FLD_W = 14;
  localparam int unsigned RES_W = 18;
  localparam int unsigned TIX_W = 4;

  // Widths that follow from the capacity.
  localparam int unsigned IDX_W = (TASK_MAX > 1) ? $clog2(TASK_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(TASK_MAX + 1);
  // The clock can reach the largest arrival plus every burst of a full set.
  localparam int unsigned CLK_W = $clog2((TASK_MAX + 1) * ((2 ** FLD_W) - 1) + 1);

  // One input transaction.
  typedef struct packed {
    logic [FLD_W-1:0] arrival_time;
    logic [FLD_W-1:0] burst_time;
    logic [FLD_W-1:0] priority_level;
    logic             last_item;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [TIX_W-1:0] task_index;
    logic [RES_W-1:0] completion_time;
    logic [RES_W-1:0] turnaround_time;
    logic [RES_W-1:0] waiting_time;
    logic             overflow;
    logic             last_result;
  } out_item_t;

  // One stored task descriptor.
  typedef struct packed {
    logic [FLD_W-1:0] arr;
    logic [FLD_W-1:0] bur;
    logic [FLD_W-1:0] pri;
    logic [FLD_W-1:0] rem;
  } task_ent_t;

  // Write request into the task store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    task_ent_t        data;
  } ram_wr_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    alu_op_e          op;
    logic [CLK_W-1:0] a;
    logic [CLK_W-1:0] b;
  } alu_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIFF,
    ST_ADV,
    ST_DECR,
    ST_TAT,
    ST_WT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/pps_task_ram.sv
// Task descriptor store: one write port and one registered read port.
`default_nettype none

module pps_task_ram (
  input  wire                            clk_i,
  input  pps_pkg::ram_wr_t               wr_i,
  input  wire                            rd_en_i,
  input  wire  [pps_pkg::IDX_W-1:0]      rd_addr_i,
  output pps_pkg::task_ent_t             rd_data_o
);

  pps_pkg::task_ent_t mem_q [pps_pkg::TASK_MAX];
  pps_pkg::task_ent_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/pps_alu.sv
// Shared adder and subtractor used by the scheduling sequencer.
`default_nettype none

module pps_alu (
  input  pps_pkg::alu_req_t         req_i,
  output logic [pps_pkg::CLK_W-1:0] res_o
);

  // A single add or subtract per cycle, wrapping at the clock width.
  always_comb begin
    case (req_i.op)
      pps_pkg::ALU_ADD: res_o = req_i.a + req_i.b;
      pps_pkg::ALU_SUB: res_o = req_i.a - req_i.b;
      default:          res_o = req_i.a;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/preemptive_priority_scheduler_core.sv
// Top level: load channel, scheduling sequencer and result register.
//
// Task descriptors arrive on the input channel (valid/ready), one per
// transaction, and are stored in load order. Descriptors beyond the store
// capacity are dropped and flagged. The transaction marked last starts
// the simulation of the set; the input channel is not ready until the
// final result of the set has been placed in the output register. The
// simulation advances from one scheduling point (an arrival or a
// completion) to the next. Each point costs a scan of the stored tasks
// through the single read port of the task store, a decision and an
// advance of the clock, and for a task that completes, the computation
// of its turnaround and waiting times. A set of n tasks has at most
// 2n + 1 scheduling points.
// Results leave in completion order through an output register. While the
// receiver stalls, the sequencer waits with the next result and resumes
// as soon as the register is taken. After reset the store is empty, the
// clock is zero and no result is pending.
`default_nettype none

module preemptive_priority_scheduler_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  pps_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output pps_pkg::out_item_t  out_data_o
);

  localparam int unsigned IDX_W = pps_pkg::IDX_W;
  localparam int unsigned CNT_W = pps_pkg::CNT_W;
  localparam int unsigned CLK_W = pps_pkg::CLK_W;
  localparam int unsigned FLD_W = pps_pkg::FLD_W;

  // Control state.
  pps_pkg::state_e      state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [CLK_W-1:0]     clkc_q, clkc_d;
  logic [CNT_W-1:0]     done_q, done_d;
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic                 rv_q, rv_d;
  logic                 sel_vld_q, sel_vld_d;
  logic                 nxt_vld_q, nxt_vld_d;
  logic                 out_vld_q, out_vld_d;

  // Working data.
  logic [IDX_W-1:0]     ridx_q, ridx_d;
  logic [IDX_W-1:0]     sel_idx_q, sel_idx_d;
  pps_pkg::task_ent_t   sel_ent_q, sel_ent_d;
  logic [FLD_W-1:0]     nxt_arr_q, nxt_arr_d;
  logic [CLK_W-1:0]     step_q, step_d;
  logic [CLK_W-1:0]     tat_q, tat_d;
  logic [CLK_W-1:0]     wt_q, wt_d;
  pps_pkg::out_item_t   out_dat_q, out_dat_d;

  // Store and arithmetic unit connections.
  pps_pkg::ram_wr_t     ram_wr;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  pps_pkg::task_ent_t   rd_data;
  pps_pkg::alu_req_t    alu_req;
  logic [CLK_W-1:0]     alu_res;

  // Scan evaluation of the entry just read.
  logic                 ent_unfin;
  logic                 ent_ready;
  logic                 ent_better;
  logic                 ent_pend;
  logic [FLD_W-1:0]     bur_fix;
  logic [CLK_W-1:0]     rem_ext;

  pps_task_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pps_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // Ready and pending tests, and the priority order with arrival tie-break.
  assign ent_unfin  = (rd_data.rem != '0);
  assign ent_ready  = ent_unfin && (CLK_W'(rd_data.arr) <= clkc_q);
  assign ent_pend   = ent_unfin && (CLK_W'(rd_data.arr) > clkc_q);
  assign ent_better = !sel_vld_q || (rd_data.pri < sel_ent_q.pri) ||
                      ((rd_data.pri == sel_ent_q.pri) && (rd_data.arr < sel_ent_q.arr));
  assign bur_fix    = (in_data_i.burst_time == '0) ? FLD_W'(1) : in_data_i.burst_time;
  assign rem_ext    = CLK_W'(sel_ent_q.rem);

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    clkc_d    = clkc_q;
    done_d    = done_q;
    iss_d     = iss_q;
    rv_d      = 1'b0;
    sel_vld_d = sel_vld_q;
    nxt_vld_d = nxt_vld_q;
    out_vld_d = out_vld_q;
    ridx_d    = ridx_q;
    sel_idx_d = sel_idx_q;
    sel_ent_d = sel_ent_q;
    nxt_arr_d = nxt_arr_q;
    step_d    = step_q;
    tat_d     = tat_q;
    wt_d      = wt_q;
    out_dat_d = out_dat_q;
    ram_wr    = '0;
    rd_en     = 1'b0;
    rd_addr   = iss_q[IDX_W-1:0];
    alu_req   = '{op: pps_pkg::ALU_ADD, a: '0, b: '0};

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q < CNT_W'(pps_pkg::TASK_MAX)) begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = cnt_q[IDX_W-1:0];
            ram_wr.data = '{arr: in_data_i.arrival_time, bur: bur_fix,
                            pri: in_data_i.priority_level, rem: bur_fix};
            cnt_d       = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_item) begin
            state_d   = pps_pkg::ST_SCAN;
            clkc_d    = '0;
            done_d    = '0;
            iss_d     = '0;
            sel_vld_d = 1'b0;
            nxt_vld_d = 1'b0;
          end
        end
      end

      pps_pkg::ST_SCAN: begin
        // Issue one read per cycle and judge the entry read the cycle before.
        if (iss_q < cnt_q) begin
          rd_en  = 1'b1;
          rv_d   = 1'b1;
          ridx_d = iss_q[IDX_W-1:0];
          iss_d  = iss_q + CNT_W'(1);
        end else if (!rv_q) begin
          state_d = pps_pkg::ST_DECIDE;
        end
        if (rv_q) begin
          if (ent_ready && ent_better) begin
            sel_vld_d = 1'b1;
            sel_idx_d = ridx_q;
            sel_ent_d = rd_data;
          end
          if (ent_pend && (!nxt_vld_q || (rd_data.arr < nxt_arr_q))) begin
            nxt_vld_d = 1'b1;
            nxt_arr_d = rd_data.arr;
          end
        end
      end

      pps_pkg::ST_DECIDE: begin
        if (!sel_vld_q) begin
          // Idle processor: jump to the earliest pending arrival.
          clkc_d    = CLK_W'(nxt_arr_q);
          state_d   = pps_pkg::ST_SCAN;
          iss_d     = '0;
          nxt_vld_d = 1'b0;
        end else if (nxt_vld_q) begin
          state_d = pps_pkg::ST_DIFF;
        end else begin
          step_d  = rem_ext;
          state_d = pps_pkg::ST_ADV;
        end
      end

      pps_pkg::ST_DIFF: begin
        // Run until the next arrival or until the task completes.
        alu_req = '{op: pps_pkg::ALU_SUB, a: CLK_W'(nxt_arr_q), b: clkc_q};
        step_d  = (alu_res < rem_ext) ? alu_res : rem_ext;
        state_d = pps_pkg::ST_ADV;
      end

      pps_pkg::ST_ADV: begin
        alu_req = '{op: pps_pkg::ALU_ADD, a: clkc_q, b: step_q};
        clkc_d  = alu_res;
        state_d = pps_pkg::ST_DECR;
      end

      pps_pkg::ST_DECR: begin
        alu_req           = '{op: pps_pkg::ALU_SUB, a: rem_ext, b: step_q};
        sel_ent_d.rem     = alu_res[FLD_W-1:0];
        ram_wr.we         = 1'b1;
        ram_wr.addr       = sel_idx_q;
        ram_wr.data       = sel_ent_q;
        ram_wr.data.rem   = alu_res[FLD_W-1:0];
        if (alu_res == '0) begin
          state_d = pps_pkg::ST_TAT;
        end else begin
          state_d   = pps_pkg::ST_SCAN;
          iss_d     = '0;
          sel_vld_d = 1'b0;
          nxt_vld_d = 1'b0;
        end
      end

      pps_pkg::ST_TAT: begin
        alu_req = '{op: pps_pkg::ALU_SUB, a: clkc_q, b: CLK_W'(sel_ent_q.arr)};
        tat_d   = alu_res;
        state_d = pps_pkg::ST_WT;
      end

      pps_pkg::ST_WT: begin
        alu_req = '{op: pps_pkg::ALU_SUB, a: tat_q, b: CLK_W'(sel_ent_q.bur)};
        wt_d    = alu_res;
        state_d = pps_pkg::ST_EMIT;
      end

      pps_pkg::ST_EMIT: begin
        // Hand the result over once the output register is free.
        if (!out_vld_q || out_ready_i) begin
          out_vld_d                 = 1'b1;
          out_dat_d.task_index      = pps_pkg::TIX_W'(sel_idx_q);
          out_dat_d.completion_time = pps_pkg::RES_W'(clkc_q);
          out_dat_d.turnaround_time = pps_pkg::RES_W'(tat_q);
          out_dat_d.waiting_time    = pps_pkg::RES_W'(wt_q);
          out_dat_d.overflow        = ovf_q;
          out_dat_d.last_result     = ((done_q + CNT_W'(1)) == cnt_q);
          done_d                    = done_q + CNT_W'(1);
          if ((done_q + CNT_W'(1)) == cnt_q) begin
            state_d = pps_pkg::ST_IDLE;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            clkc_d  = '0;
          end else begin
            state_d   = pps_pkg::ST_SCAN;
            iss_d     = '0;
            sel_vld_d = 1'b0;
            nxt_vld_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pps_pkg::ST_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      clkc_q    <= '0;
      done_q    <= '0;
      iss_q     <= '0;
      rv_q      <= 1'b0;
      sel_vld_q <= 1'b0;
      nxt_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      clkc_q    <= clkc_d;
      done_q    <= done_d;
      iss_q     <= iss_d;
      rv_q      <= rv_d;
      sel_vld_q <= sel_vld_d;
      nxt_vld_q <= nxt_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ridx_q    <= ridx_d;
    sel_idx_q <= sel_idx_d;
    sel_ent_q <= sel_ent_d;
    nxt_arr_q <= nxt_arr_d;
    step_q    <= step_d;
    tat_q     <= tat_d;
    wt_q      <= wt_d;
    out_dat_q <= out_dat_d;
  end

  assign in_ready_o  = (state_q == pps_pkg::ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_dat_q;

  // While a set is being simulated, fewer tasks have finished than were loaded.
  a_done_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pps_pkg::ST_IDLE) |-> (done_q < cnt_q))
    else $error("finished task count reached loaded count during simulation");

  // A result is only computed for a task with no service left.
  a_finish_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_TAT) |-> (sel_ent_q.rem == '0))
    else $error("result computed for an unfinished task");

  // With nothing ready, the clock must jump forward to a pending arrival.
  a_idle_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pps_pkg::ST_DECIDE) && !sel_vld_q) |=> (clkc_q > $past(clkc_q)))
    else $error("idle jump did not advance the clock");

  // A scan never issues a read beyond the loaded tasks.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (iss_q < cnt_q))
    else $error("store read beyond the loaded tasks");

endmodule

`default_nettype wire
